// ----- hdl/edge_masked_weighted_median_defines.svh -----
// Assertion macros shared by the filter RTL
`ifndef EDGE_MASKED_WEIGHTED_MEDIAN_DEFINES_SVH
`define EDGE_MASKED_WEIGHTED_MEDIAN_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define EMWM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication with a fixed delay of the pipeline depth
`define EMWM_ASSERT_LAT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (ante) |-> ##(emwm_pkg::PIPE_LAT) (cons)) else $error(msg);

`endif

// ----- hdl/emwm_pkg.sv -----
package emwm_pkg;

  localparam int PIX_W             = 8;
  localparam int W_W               = 4;
  localparam int NUM_TAPS          = 9;
  localparam int CENTER_TAP        = 4;
  localparam int MAX_CENTER_WEIGHT = 8;
  localparam int CNT_W             = $clog2(NUM_TAPS + MAX_CENTER_WEIGHT);
  localparam int PIPE_LAT          = NUM_TAPS + 1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [W_W-1:0]   wgt_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    pix_t [NUM_TAPS-1:0] pix;
    logic                is_edge;
    cnt_t [NUM_TAPS-1:0] lt;
    cnt_t [NUM_TAPS-1:0] le;
  } stage_t;

endpackage

// ----- hdl/edge_masked_weighted_median.sv -----
// Edge-masked centre-weighted 3x3 median filter.
// Input: drive the nine window pixels and the edge byte with start high; the
// window transfers at the rising edge where start is high and busy is low.
// busy never rises, so a new window may transfer in every cycle.
// Output: out_valid is high for one cycle with out_pixel_out and
// out_was_filtered; the receiver takes it at the edge ending that cycle.
// Pipeline: the input transfer passes a register in each rank cell (nine),
// then the selection register, before the output strobe. Throughput: one window per
// clock, set by the nine-cell comparison chain.
// Edge byte nonzero: the centre pixel passes through with out_was_filtered low.
// Configuration: cfg_data (4 bits) transfers when cfg_valid and cfg_ready are
// high; cfg_ready is always high. Weight 0 acts as 1, above 8 saturates to 8.
// Write it only while no window is in flight.
// Reset (synchronous, rst_n low): weight returns to 1 and all in-flight
// windows are dropped. The receiver cannot stall; nothing holds results back.
module edge_masked_weighted_median (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  emwm_pkg::pix_t      in_top_left,
  input  emwm_pkg::pix_t      in_top_mid,
  input  emwm_pkg::pix_t      in_top_right,
  input  emwm_pkg::pix_t      in_mid_left,
  input  emwm_pkg::pix_t      in_center_pix,
  input  emwm_pkg::pix_t      in_mid_right,
  input  emwm_pkg::pix_t      in_bottom_left,
  input  emwm_pkg::pix_t      in_bottom_mid,
  input  emwm_pkg::pix_t      in_bottom_right,
  input  logic [7:0]          in_edge_value,
  output logic                out_valid,
  output emwm_pkg::pix_t      out_pixel_out,
  output logic                out_was_filtered,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  emwm_pkg::wgt_t      cfg_data
);
  import emwm_pkg::*;

`include "edge_masked_weighted_median_defines.svh"

  wgt_t   center_weight_r;
  wgt_t   w_eff;
  cnt_t   rank_sum;
  cnt_t   rank;
  logic   accept;
  stage_t st     [NUM_TAPS+1];
  logic   st_vld [NUM_TAPS+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_weight_r <= W_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      center_weight_r <= cfg_data;
    end
  end

  always_comb begin
    w_eff = center_weight_r;
    if (center_weight_r == '0) begin
      w_eff = W_W'(1);
    end else if (center_weight_r > W_W'(MAX_CENTER_WEIGHT)) begin
      w_eff = W_W'(MAX_CENTER_WEIGHT);
    end
  end

  assign rank_sum = CNT_W'(w_eff) + CNT_W'(NUM_TAPS - 1);
  assign rank     = rank_sum >> 1;

  always_comb begin
    st[0]         = '0;
    st[0].pix[0]  = in_top_left;
    st[0].pix[1]  = in_top_mid;
    st[0].pix[2]  = in_top_right;
    st[0].pix[3]  = in_mid_left;
    st[0].pix[4]  = in_center_pix;
    st[0].pix[5]  = in_mid_right;
    st[0].pix[6]  = in_bottom_left;
    st[0].pix[7]  = in_bottom_mid;
    st[0].pix[8]  = in_bottom_right;
    st[0].is_edge = (in_edge_value != 8'd0);
  end

  assign st_vld[0] = accept;

  for (genvar k = 0; k < NUM_TAPS; k++) begin : g_cell
    emwm_rank_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_vld    (st_vld[k]),
      .in_stage  (st[k]),
      .probe_pix (st[k].pix[k]),
      .probe_wgt ((k == CENTER_TAP) ? w_eff : W_W'(1)),
      .out_vld   (st_vld[k+1]),
      .out_stage (st[k+1])
    );
  end

  emwm_select u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (st_vld[NUM_TAPS]),
    .in_stage (st[NUM_TAPS]),
    .rank     (rank),
    .out_vld  (out_valid),
    .out_pix  (out_pixel_out),
    .out_filt (out_was_filtered)
  );

  `EMWM_ASSERT_LAT(a_transfer_gives_result, start && !busy, out_valid,
    "accepted window produced no result")
  `EMWM_ASSERT_NOW(a_result_has_source, out_valid, $past(start && !busy, PIPE_LAT),
    "result without an accepted window")
  `EMWM_ASSERT_NOW(a_pass_on_edge, out_valid && !out_was_filtered,
    $past(in_edge_value != 8'd0, PIPE_LAT) && out_pixel_out == $past(in_center_pix, PIPE_LAT),
    "edge window did not pass the centre pixel")

endmodule

// ----- hdl/emwm_rank_cell.sv -----
module emwm_rank_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  emwm_pkg::stage_t in_stage,
  input  emwm_pkg::pix_t  probe_pix,
  input  emwm_pkg::wgt_t  probe_wgt,
  output logic            out_vld,
  output emwm_pkg::stage_t out_stage
);
  import emwm_pkg::*;

  logic   vld_r;
  stage_t stage_r;
  stage_t stage_nxt;

  always_comb begin
    stage_nxt = in_stage;
    for (int i = 0; i < NUM_TAPS; i++) begin
      if (probe_pix < in_stage.pix[i]) begin
        stage_nxt.lt[i] = in_stage.lt[i] + CNT_W'(probe_wgt);
      end
      if (probe_pix <= in_stage.pix[i]) begin
        stage_nxt.le[i] = in_stage.le[i] + CNT_W'(probe_wgt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  assign out_vld   = vld_r;
  assign out_stage = stage_r;

endmodule

// ----- hdl/emwm_select.sv -----
module emwm_select (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  emwm_pkg::stage_t in_stage,
  input  emwm_pkg::cnt_t   rank,
  output logic             out_vld,
  output emwm_pkg::pix_t   out_pix,
  output logic             out_filt
);
  import emwm_pkg::*;

  logic                vld_r;
  pix_t                pix_r;
  pix_t                pix_nxt;
  logic                filt_r;
  logic [NUM_TAPS-1:0] hit;

  always_comb begin
    for (int i = 0; i < NUM_TAPS; i++) begin
      hit[i] = (in_stage.lt[i] <= rank) && (rank < in_stage.le[i]);
    end
  end

  always_comb begin
    pix_nxt = in_stage.pix[CENTER_TAP];
    if (!in_stage.is_edge) begin
      for (int i = NUM_TAPS - 1; i >= 0; i--) begin
        if (hit[i]) begin
          pix_nxt = in_stage.pix[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    pix_r  <= pix_nxt;
    filt_r <= !in_stage.is_edge;
  end

  assign out_vld  = vld_r;
  assign out_pix  = pix_r;
  assign out_filt = filt_r;

endmodule

// ----- test/edge_masked_weighted_median_tb.sv -----
module edge_masked_weighted_median_tb;
  import emwm_pkg::*;

  localparam int RANDOM_ITEMS   = 900;
  localparam int PHASES         = 10;
  localparam int WATCHDOG_LIMIT = 200;
  localparam int LIST_LEN       = NUM_TAPS + MAX_CENTER_WEIGHT - 1;

  typedef struct packed {
    pix_t [NUM_TAPS-1:0] taps;
    logic [7:0]          edge_byte;
  } window_t;

  typedef struct packed {
    pix_t pixel;
    logic filtered;
  } filt_result_t;

  logic    clk;
  logic    rst_n;
  logic    start;
  logic    busy;
  window_t drv_win;
  logic    out_valid;
  pix_t    out_pixel_out;
  logic    out_was_filtered;
  logic    cfg_valid;
  logic    cfg_ready;
  wgt_t    cfg_data;

  filt_result_t pending_pixels[$];
  filt_result_t oldest;
  wgt_t         weight_reg;
  bit           calm;
  int           mismatches;
  int           quiet_cycles;

  edge_masked_weighted_median dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_top_left     (drv_win.taps[0]),
    .in_top_mid      (drv_win.taps[1]),
    .in_top_right    (drv_win.taps[2]),
    .in_mid_left     (drv_win.taps[3]),
    .in_center_pix   (drv_win.taps[4]),
    .in_mid_right    (drv_win.taps[5]),
    .in_bottom_left  (drv_win.taps[6]),
    .in_bottom_mid   (drv_win.taps[7]),
    .in_bottom_right (drv_win.taps[8]),
    .in_edge_value   (drv_win.edge_byte),
    .out_valid       (out_valid),
    .out_pixel_out   (out_pixel_out),
    .out_was_filtered(out_was_filtered),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic filt_result_t weighted_median(window_t w, wgt_t weight);
    pix_t         list [LIST_LEN];
    int           eff;
    int           n;
    int           rank;
    int           lt;
    int           le;
    filt_result_t r;
    r.pixel    = w.taps[CENTER_TAP];
    r.filtered = 1'b0;
    if (w.edge_byte != 8'd0) return r;
    eff = (weight == 0) ? 1 : ((weight > MAX_CENTER_WEIGHT) ? MAX_CENTER_WEIGHT : weight);
    n = 0;
    for (int i = 0; i < NUM_TAPS; i++) begin
      list[n] = w.taps[i];
      n++;
    end
    for (int i = 1; i < eff; i++) begin
      list[n] = w.taps[CENTER_TAP];
      n++;
    end
    rank = n / 2;
    for (int i = 0; i < n; i++) begin
      lt = 0;
      le = 0;
      for (int j = 0; j < n; j++) begin
        if (list[j] < list[i]) lt++;
        if (list[j] <= list[i]) le++;
      end
      if (lt <= rank && rank < le) r.pixel = list[i];
    end
    r.filtered = 1'b1;
    return r;
  endfunction

  function automatic window_t flat_window(pix_t centre, pix_t others, logic [7:0] e);
    window_t w;
    for (int i = 0; i < NUM_TAPS; i++) w.taps[i] = others;
    w.taps[CENTER_TAP] = centre;
    w.edge_byte        = e;
    return w;
  endfunction

  function automatic window_t random_window(int flat_pct);
    window_t w;
    int      style;
    int      base;
    style = $urandom_range(3);
    base  = $urandom_range(255);
    for (int i = 0; i < NUM_TAPS; i++) begin
      case (style)
        0: w.taps[i] = pix_t'($urandom_range(255));
        1: w.taps[i] = pix_t'((base + $urandom_range(6)) & 8'hFF);
        2: w.taps[i] = $urandom_range(1) ? 8'hFF : 8'h00;
        default: w.taps[i] = pix_t'($urandom_range(3) == 0 ? $urandom_range(255) : base);
      endcase
    end
    w.edge_byte = ($urandom_range(99) < flat_pct) ? 8'd0 : 8'($urandom_range(1, 255));
    return w;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic send_window(window_t w);
    @(negedge clk);
    start   = 1'b1;
    drv_win = w;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_pixels.push_back(weighted_median(w, weight_reg));
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(99) < 13) begin
      repeat ($urandom_range(1, 3)) begin
        @(negedge clk);
        start = 1'b0;
      end
    end
  endtask

  task automatic drain(bit settle);
    @(negedge clk);
    start = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    if (settle) repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic write_weight(wgt_t v);
    drain(1'b1);
    if ($urandom_range(99) < 21) repeat ($urandom_range(1, 3)) @(negedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    weight_reg = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_default_weight();
    window_t w;
    send_window(flat_window(8'h00, 8'h00, 8'h00));
    send_window(flat_window(8'hFF, 8'hFF, 8'h00));
    send_window(flat_window(8'hFF, 8'h00, 8'h00));
    send_window(flat_window(8'h00, 8'hFF, 8'h00));
    for (int i = 0; i < NUM_TAPS; i++) w.taps[i] = pix_t'(255 - i * 31);
    w.edge_byte = 8'h00;
    send_window(w);
  endtask

  task automatic test_edge_bypass();
    window_t w;
    w = random_window(0);
    w.edge_byte = 8'h01;
    send_window(w);
    send_window(flat_window(8'hFF, 8'h00, 8'h80));
    send_window(flat_window(8'h00, 8'hFF, 8'hFF));
    send_window(flat_window(8'hA5, 8'h5A, 8'h7F));
  endtask

  task automatic test_weight_extremes();
    wgt_t ladder [5] = '{4'd8, 4'd0, 4'd15, 4'd9, 4'd1};
    window_t w;
    for (int i = 0; i < NUM_TAPS; i++) w.taps[i] = pix_t'(i * 28);
    w.taps[CENTER_TAP] = 8'hFF;
    w.edge_byte        = 8'h00;
    foreach (ladder[k]) begin
      write_weight(ladder[k]);
      send_window(flat_window(8'hFF, 8'h00, 8'h00));
      send_window(flat_window(8'h00, 8'hFF, 8'h00));
      send_window(w);
    end
  endtask

  task automatic test_random_windows();
    wgt_t sched [PHASES] = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd9, 4'd1, 4'd6, 4'd12, 4'd2, 4'd7};
    for (int p = 0; p < PHASES; p++) begin
      write_weight(sched[p]);
      calm = (p == 2);
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        if (p == 4 && i == 45) drain(1'b0);
        send_window(random_window(70));
        maybe_gap();
      end
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("result with nothing pending", int'(out_pixel_out), -1);
      end else begin
        oldest = pending_pixels.pop_front();
        if (out_pixel_out !== oldest.pixel)
          report_mismatch("out_pixel_out", int'(out_pixel_out), int'(oldest.pixel));
        if (out_was_filtered !== oldest.filtered)
          report_mismatch("out_was_filtered", int'(out_was_filtered), int'(oldest.filtered));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    drv_win      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    weight_reg   = 4'd1;
    calm         = 1'b0;
    mismatches   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_default_weight();
    test_edge_bypass();
    test_weight_extremes();
    test_random_windows();
    drain(1'b1);
    if (pending_pixels.size() != 0)
      report_mismatch("results never arrived", 0, pending_pixels.size());
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
